// ----- hw/rtl/spq_pkg.sv -----
// spq_pkg: shared types and constants for the sorted priority queue
// no dependencies; imported by spq_cell, the top level and the bench
`default_nettype none

package spq_pkg;

    // default number of cells in the queue
    localparam int SPQ_DEPTH = 16;

    // width of one stored entry
    localparam int DATA_W = 32;

    // request commands
    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // per-cycle shift control broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- hw/rtl/spq_cell.sv -----
// spq_cell: one cell of the sorted chain, holds one entry
// depends on spq_pkg; instantiated in a row by sorted_priority_queue
`default_nettype none

module spq_cell (
    input  wire                             i_clk,
    input  wire spq_pkg::t_cell_ctrl        i_ctrl,
    input  wire                             i_occupied,
    input  wire signed [spq_pkg::DATA_W-1:0] i_value,
    input  wire                             i_left_less,
    input  wire signed [spq_pkg::DATA_W-1:0] i_left_entry,
    input  wire signed [spq_pkg::DATA_W-1:0] i_right_entry,
    output logic                            o_less,
    output logic signed [spq_pkg::DATA_W-1:0] o_entry
);
    import spq_pkg::*;

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;

    // entry held here is smaller than the incoming value
    assign o_less = i_occupied && (r_entry < i_value);

    // insert: keep if smaller, take new value at the boundary, else shift right
    // remove: shift left toward the head
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins_en) begin
            if (o_less) begin
                n_entry = r_entry;
            end else if (i_left_less) begin
                n_entry = i_value;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctrl.rem_en) begin
            n_entry = i_right_entry;
        end
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_priority_queue.sv -----
// A result appears in the output register in the cycle after the request is accepted.
// Throughput: one request per cycle if not stalled; cells compare to the new value at once.
// A result held in the output register stalls the input until the receiver takes it.
// Reset (synchronous, active low) clears the occupancy count and the output valid.
// Entry cells are not reset; only cells below the occupancy count are ever read.
// sorted_priority_queue: top level, row of spq_cell plus count and result register
`default_nettype none

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_command,
    input  wire signed [spq_pkg::DATA_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic signed [spq_pkg::DATA_W-1:0] o_removed_value,
    output logic [1:0]                        o_status,
    output logic                              o_is_empty
);
    import spq_pkg::*;

    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        n_count;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_removed;
    logic [1:0]                r_status;
    logic                      r_is_empty;

    logic                      w_accept;
    logic                      w_full;
    logic                      w_empty;
    logic                      w_is_remove;
    t_cell_ctrl                w_ctrl;

    logic [DEPTH-1:0]          w_less;
    logic signed [DATA_W-1:0]  w_entry [DEPTH];

    // handshake
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_full      = (r_count == COUNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_is_remove = (i_command == CMD_REMOVE);

    // shift control for the cell row
    assign w_ctrl.ins_en = w_accept && !w_is_remove && !w_full;
    assign w_ctrl.rem_en = w_accept && w_is_remove && !w_empty;

    // row of cells
    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            logic                     w_left_less;
            logic signed [DATA_W-1:0] w_left_entry;
            logic signed [DATA_W-1:0] w_right_entry;

            if (k == 0) begin : g_head
                assign w_left_less  = 1'b1;
                assign w_left_entry = i_value;
            end else begin : g_mid
                assign w_left_less  = w_less[k-1];
                assign w_left_entry = w_entry[k-1];
            end

            if (k == DEPTH - 1) begin : g_tail
                assign w_right_entry = w_entry[k];
            end else begin : g_body
                assign w_right_entry = w_entry[k+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_occupied    (COUNT_W'(k) < r_count),
                .i_value       (i_value),
                .i_left_less   (w_left_less),
                .i_left_entry  (w_left_entry),
                .i_right_entry (w_right_entry),
                .o_less        (w_less[k]),
                .o_entry       (w_entry[k])
            );
        end
    endgenerate

    // occupancy count
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins_en) begin
            n_count = r_count + 1'b1;
        end else if (w_ctrl.rem_en) begin
            n_count = r_count - 1'b1;
        end
    end

    // count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_removed  <= w_ctrl.rem_en ? w_entry[0] : '0;
            r_is_empty <= (n_count == '0);
            if (w_is_remove && w_empty) begin
                r_status <= ST_EMPTY;
            end else if (!w_is_remove && w_full) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_DONE;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_is_empty      = r_is_empty;

    // count stays within the cell row
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    // a remove from a non-empty queue drops the count by one
    a_remove_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.rem_en |=> r_count == $past(r_count) - 1'b1)
        else $error("remove did not decrement occupancy");

    // head pair stays in ascending order
    a_head_sorted : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= COUNT_W'(2) |-> w_entry[0] <= w_entry[1])
        else $error("head entries out of order");

    // an empty status always reports an empty queue
    a_empty_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_EMPTY) |-> r_is_empty)
        else $error("empty status with non-empty queue");

    // an insert into a full queue leaves the count unchanged
    a_full_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_remove && w_full) |=> r_count == $past(r_count))
        else $error("full insert changed occupancy");

endmodule

`default_nettype wire

// ----- test/tb_sorted_priority_queue.sv -----
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue
// depends on spq_pkg and sorted_priority_queue; a local sorted list predicts each result
`default_nettype none

module tb_sorted_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = SPQ_DEPTH;
    localparam int HOLD_CYCLES = 60;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // one expected response of the queue
    typedef struct {
        logic signed [DATA_W-1:0] removed;
        t_status                  status;
        logic                     is_empty;
    } t_queue_result;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     command = CMD_INSERT;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_ready = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_removed_value;
    logic [1:0]               o_status;
    logic                     o_is_empty;

    // predictor state and pending responses
    logic signed [DATA_W-1:0] model_entries[$];
    t_queue_result            expected_results[$];

    bit send_gaps = 1'b1;
    bit recv_stalls = 1'b1;
    bit hold_start = 1'b0;
    bit hold_active = 1'b0;
    int stall_left = 0;
    int error_count = 0;
    int cycle_count = 0;
    int n_inserted = 0;
    int n_removed = 0;
    int n_full = 0;
    int n_empty = 0;

    sorted_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (command),
        .i_value        (value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_removed_value(o_removed_value),
        .o_status       (o_status),
        .o_is_empty     (o_is_empty)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses pending", cycle_count,
                     expected_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // sorted-list behavior of one request, updates the local copy of the queue
    function automatic t_queue_result predict_queue_step(input t_cmd cmd,
                                                         input logic signed [DATA_W-1:0] val);
        t_queue_result res;
        int pos;
        res.removed = '0;
        res.status = ST_DONE;
        if (cmd == CMD_INSERT) begin
            if (model_entries.size() >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < model_entries.size() && model_entries[pos] < val) pos++;
                model_entries.insert(pos, val);
            end
        end else if (model_entries.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.removed = model_entries.pop_front();
        end
        res.is_empty = (model_entries.size() == 0);
        return res;
    endfunction

    // offer one request and wait for it to be taken; called at a rising edge
    task automatic send_request(input t_cmd cmd, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = send_gaps ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        value <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(predict_queue_step(cmd, val));
    endtask

    // half full-range values, some extremes and a narrow band for duplicates
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    // response side: random stall per response, long hold when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (out_ready && o_out_valid)
                stall_left = recv_stalls ? $urandom_range(0, 4) : 0;
            else if (stall_left > 0)
                stall_left--;
            out_ready <= (stall_left == 0) && !hold_active;
        end
    end

    // long receiver hold, counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_active = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_active = 1'b0;
            end
        end
    end

    // compare each taken response with the oldest prediction
    always @(posedge i_clk) begin
        t_queue_result exp_res;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected response value=%0d status=%0d",
                                          o_removed_value, o_status));
            end else begin
                exp_res = expected_results.pop_front();
                if (o_removed_value !== exp_res.removed)
                    report_mismatch($sformatf("removed_value got %0d want %0d",
                                              o_removed_value, exp_res.removed));
                if (o_status !== exp_res.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, exp_res.status));
                if (o_is_empty !== exp_res.is_empty)
                    report_mismatch($sformatf("is_empty got %0b want %0b",
                                              o_is_empty, exp_res.is_empty));
                case (exp_res.status)
                    ST_FULL:  n_full++;
                    ST_EMPTY: n_empty++;
                    default:  ;
                endcase
            end
        end
    end

    // count accepted requests by command as they are predicted
    always @(posedge i_clk) begin
        if (in_valid && o_in_ready && i_rst_n) begin
            if (command == CMD_INSERT) n_inserted++;
            else n_removed++;
        end
    end

    // removes on an empty queue, extremes, equal values, new minimum at the head
    task automatic test_directed();
        send_request(CMD_REMOVE, VAL_MAX);
        send_request(CMD_REMOVE, '0);
        send_request(CMD_INSERT, '0);
        send_request(CMD_INSERT, VAL_MAX);
        send_request(CMD_INSERT, VAL_MIN);
        send_request(CMD_INSERT, -1);
        send_request(CMD_INSERT, -1);
        send_request(CMD_INSERT, VAL_MAX);
        send_request(CMD_INSERT, 1);
        send_request(CMD_INSERT, VAL_MIN);
        repeat (9) send_request(CMD_REMOVE, $urandom);
    endtask

    // fill to capacity, overflow twice, then drain past empty
    task automatic test_fill_overflow();
        while (model_entries.size() < QUEUE_DEPTH) send_request(CMD_INSERT, pick_value());
        repeat (2) send_request(CMD_INSERT, pick_value());
        while (model_entries.size() > 0) send_request(CMD_REMOVE, $urandom);
        send_request(CMD_REMOVE, $urandom);
    endtask

    // random mix in phases that push the occupancy up and down
    task automatic test_random_mix();
        int insert_pct[4] = '{75, 25, 65, 35};
        for (int ph = 0; ph < 4; ph++) begin
            repeat (100) begin
                if ($urandom_range(1, 100) <= insert_pct[ph])
                    send_request(CMD_INSERT, pick_value());
                else
                    send_request(CMD_REMOVE, $urandom);
            end
        end
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        send_gaps = 1'b0;
        hold_start = 1'b1;
        repeat (20) send_request(CMD_INSERT, pick_value());
        repeat (12) send_request(CMD_REMOVE, $urandom);
        send_gaps = 1'b1;
    endtask

    // back-to-back traffic with no idling on either side
    task automatic test_streaming();
        send_gaps = 1'b0;
        recv_stalls = 1'b0;
        repeat (60) begin
            if ($urandom_range(0, 1)) send_request(CMD_INSERT, pick_value());
            else send_request(CMD_REMOVE, $urandom);
        end
        while (model_entries.size() > 0) send_request(CMD_REMOVE, $urandom);
        send_gaps = 1'b1;
        recv_stalls = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_fill_overflow();
        test_random_mix();
        test_backpressure();
        test_streaming();
        in_valid <= 1'b0;

        // drain, then idle to catch anything stray
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        $display("covered %0d inserts and %0d removes, %0d rejected as full, %0d on empty",
                 n_inserted, n_removed, n_full, n_empty);
        $display("directed extremes, fill and overflow, random phases, long hold, streaming");
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
